### rtl/core/bline_pkg.sv
// Shared constants, codes and width helpers for the Bresenham line point generator.
// No dependencies; every other file of the block imports this package.
package bline_pkg;

  // Default coordinate width in bits (signed)
  localparam int unsigned COORD_BITS_DEF = 12;

  localparam int unsigned PANEL_W     = 16;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned OFFSET_W    = 8;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Request codes
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_type_e;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_X_OFFSET = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_Y_OFFSET = CFG_ADDR_W'(1);

  // Error term width: the term stays within +/- 2^coord, plus a guard bit
  function automatic int unsigned err_width(int unsigned coord);
    return coord + 3;
  endfunction

  // Width of one queue entry: start flag, two directions, four coordinates,
  // |dx|, -|dy|, initial error term and colour
  function automatic int unsigned entry_width(int unsigned coord);
    return 7 * coord + 23;
  endfunction

endpackage

### rtl/core/bline_if.sv
// Handshake channel interfaces of the line point generator: request, point and config write.
// Depends on bline_pkg for widths.
interface bline_req_if
  import bline_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic        [COLOR_W-1:0]    pen_color;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, pen_color,
                  input ready);
  modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, pen_color,
                  output ready);
endinterface

interface bline_pt_if
  import bline_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic        [PANEL_W-1:0]    panel_x;
  logic        [PANEL_W-1:0]    panel_y;
  logic        [COLOR_W-1:0]    point_color;
  logic                         visible;
  logic                         last;

  modport source (output valid, point_x, point_y, panel_x, panel_y, point_color, visible,
                  last, input ready);
  modport sink   (input valid, point_x, point_y, panel_x, panel_y, point_color, visible,
                  last, output ready);
endinterface

interface bline_cfg_if
  import bline_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [OFFSET_W-1:0]   wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

### rtl/core/bline_front.sv
// Front end: accepts requests, precomputes direction, deltas and initial error term.
// Depends on bline_pkg and bline_req_if; feeds the request queue.
module bline_front
  import bline_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  bline_req_if.sink                                 req_i,
  output logic                                      push_valid_o,
  input  logic                                      push_ready_i,
  output logic [entry_width(COORD_BITS)-1:0]        push_data_o
);

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned E = err_width(COORD_BITS);

  typedef struct packed {
    logic                is_start;
    logic                step_x_neg;
    logic                step_y_neg;
    logic signed [C-1:0] sx;
    logic signed [C-1:0] sy;
    logic signed [C-1:0] gx;
    logic signed [C-1:0] gy;
    logic        [C-1:0] dx;
    logic signed [C:0]   ndy;
    logic signed [E-1:0] err;
    logic [COLOR_W-1:0]  color;
  } entry_t;

  entry_t              entry;
  logic signed [C:0]   diff_x;
  logic signed [C:0]   diff_y;
  logic signed [C:0]   abs_x;

  // Endpoint differences, one bit wider than a coordinate
  assign diff_x = (C+1)'(req_i.end_x) - (C+1)'(req_i.start_x);
  assign diff_y = (C+1)'(req_i.end_y) - (C+1)'(req_i.start_y);
  assign abs_x  = diff_x[C] ? -diff_x : diff_x;

  // Classify and build the entry for the back end
  always_comb begin
    entry            = '0;
    entry.is_start   = (req_i.req_type == REQ_START);
    entry.step_x_neg = !(req_i.start_x < req_i.end_x);
    entry.step_y_neg = !(req_i.start_y < req_i.end_y);
    entry.sx         = req_i.start_x;
    entry.sy         = req_i.start_y;
    entry.gx         = req_i.end_x;
    entry.gy         = req_i.end_y;
    entry.dx         = abs_x[C-1:0];
    entry.ndy        = (!diff_y[C] && (diff_y != '0)) ? -diff_y : diff_y;
    entry.err        = E'(signed'({1'b0, entry.dx})) + E'(entry.ndy);
    entry.color      = req_i.pen_color;
  end

  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;
  assign push_data_o  = entry;

endmodule

### rtl/core/bline_fifo.sv
// Short register queue between the front and back ends.
// Depends on bline_pkg for the default depth.
module bline_fifo
  import bline_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/core/bline_back.sv
// Back end: holds the line state, loads a start item or runs one Bresenham step, drives the point register.
// Depends on bline_pkg, bline_pt_if and bline_cfg_if; takes entries from the request queue.
module bline_back
  import bline_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               pop_valid_i,
  output logic                               pop_ready_o,
  input  logic [entry_width(COORD_BITS)-1:0] pop_data_i,
  bline_cfg_if.sink                          cfg_i,
  bline_pt_if.source                         pt_o
);

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned E = err_width(COORD_BITS);

  typedef struct packed {
    logic                is_start;
    logic                step_x_neg;
    logic                step_y_neg;
    logic signed [C-1:0] sx;
    logic signed [C-1:0] sy;
    logic signed [C-1:0] gx;
    logic signed [C-1:0] gy;
    logic        [C-1:0] dx;
    logic signed [C:0]   ndy;
    logic signed [E-1:0] err;
    logic [COLOR_W-1:0]  color;
  } entry_t;

  entry_t entry;
  assign entry = pop_data_i;

  // Line state
  logic signed [C-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [C-1:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic                sxn_q, sxn_d, syn_q, syn_d;
  logic        [C-1:0] dx_q, dx_d;
  logic signed [C:0]   ndy_q, ndy_d;
  logic signed [E-1:0] err_q, err_d;
  logic [COLOR_W-1:0]  color_q, color_d;
  logic                active_q, active_d;

  // Configuration
  logic [OFFSET_W-1:0] x_off_q, x_off_d, y_off_q, y_off_d;

  // Point register
  logic                out_valid_q, out_valid_d;
  logic signed [C-1:0] px_q, px_d, py_q, py_d;
  logic [PANEL_W-1:0]  panx_q, panx_d, pany_q, pany_d;
  logic [COLOR_W-1:0]  pcol_q, pcol_d;
  logic                vis_q, vis_d, last_q, last_d;

  logic                out_free, pop_fire, emit, at_end, mx, my;
  logic signed [E:0]   e2, ndy_w, dx_w;
  logic signed [C-1:0] nx, ny, gx, gy;

  assign out_free    = !out_valid_q || pt_o.ready;
  assign pop_ready_o = out_free;
  assign pop_fire    = pop_valid_i && out_free;
  assign emit        = entry.is_start || active_q;

  // Step decisions on the registered error term
  assign e2    = signed'({err_q, 1'b0});
  assign ndy_w = (E+1)'(ndy_q);
  assign dx_w  = (E+1)'(signed'({1'b0, dx_q}));
  assign mx    = (e2 >= ndy_w);
  assign my    = (e2 <= dx_w);

  // Next point and end test
  always_comb begin
    if (entry.is_start) begin
      nx = entry.sx;
      ny = entry.sy;
      gx = entry.gx;
      gy = entry.gy;
    end else begin
      nx = cur_x_q;
      ny = cur_y_q;
      if (mx) begin
        nx = sxn_q ? cur_x_q - C'(1) : cur_x_q + C'(1);
      end
      if (my) begin
        ny = syn_q ? cur_y_q - C'(1) : cur_y_q + C'(1);
      end
      gx = goal_x_q;
      gy = goal_y_q;
    end
  end
  assign at_end = (nx == gx) && (ny == gy);

  // Update line state
  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    sxn_d    = sxn_q;
    syn_d    = syn_q;
    dx_d     = dx_q;
    ndy_d    = ndy_q;
    err_d    = err_q;
    color_d  = color_q;
    active_d = active_q;
    if (pop_fire && emit) begin
      cur_x_d  = nx;
      cur_y_d  = ny;
      active_d = !at_end;
      if (entry.is_start) begin
        goal_x_d = entry.gx;
        goal_y_d = entry.gy;
        sxn_d    = entry.step_x_neg;
        syn_d    = entry.step_y_neg;
        dx_d     = entry.dx;
        ndy_d    = entry.ndy;
        err_d    = entry.err;
        color_d  = entry.color;
      end else begin
        err_d = err_q + (mx ? E'(ndy_q) : E'(0))
                      + (my ? E'(signed'({1'b0, dx_q})) : E'(0));
      end
    end
  end

  // Load or drain the point register
  always_comb begin
    out_valid_d = out_valid_q;
    px_d        = px_q;
    py_d        = py_q;
    panx_d      = panx_q;
    pany_d      = pany_q;
    pcol_d      = pcol_q;
    vis_d       = vis_q;
    last_d      = last_q;
    if (pop_fire && emit) begin
      out_valid_d = 1'b1;
      px_d        = nx;
      py_d        = ny;
      panx_d      = PANEL_W'(nx) + PANEL_W'(x_off_q);
      pany_d      = PANEL_W'(ny) + PANEL_W'(y_off_q);
      pcol_d      = entry.is_start ? entry.color : color_q;
      vis_d       = !nx[C-1] && !ny[C-1];
      last_d      = at_end;
    end else if (pt_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration writes
  assign cfg_i.ready = 1'b1;
  always_comb begin
    x_off_d = x_off_q;
    y_off_d = y_off_q;
    if (cfg_i.valid) begin
      case (cfg_i.addr)
        REG_X_OFFSET: x_off_d = cfg_i.wdata;
        REG_Y_OFFSET: y_off_d = cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      sxn_q       <= 1'b0;
      syn_q       <= 1'b0;
      dx_q        <= '0;
      ndy_q       <= '0;
      err_q       <= '0;
      color_q     <= '0;
      active_q    <= 1'b0;
      x_off_q     <= '0;
      y_off_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      goal_x_q    <= goal_x_d;
      goal_y_q    <= goal_y_d;
      sxn_q       <= sxn_d;
      syn_q       <= syn_d;
      dx_q        <= dx_d;
      ndy_q       <= ndy_d;
      err_q       <= err_d;
      color_q     <= color_d;
      active_q    <= active_d;
      x_off_q     <= x_off_d;
      y_off_q     <= y_off_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Point payload, no reset
  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    panx_q <= panx_d;
    pany_q <= pany_d;
    pcol_q <= pcol_d;
    vis_q  <= vis_d;
    last_q <= last_d;
  end

  assign pt_o.valid       = out_valid_q;
  assign pt_o.point_x     = px_q;
  assign pt_o.point_y     = py_q;
  assign pt_o.panel_x     = panx_q;
  assign pt_o.panel_y     = pany_q;
  assign pt_o.point_color = pcol_q;
  assign pt_o.visible     = vis_q;
  assign pt_o.last        = last_q;

endmodule

### rtl/core/bresenham_line_point_generator_unit.sv
// Bresenham line point generator, top level: front end, request queue, back end.
// An accepted request is stored in the queue; its point is then loaded into the point register.
// One request per cycle while the point output is not stalled; each step uses registered state.
// A step request with no line in progress is consumed and yields no point.
// Reset (rst_ni low, asynchronous) clears line state, offsets, queue and point valid.
// Depends on bline_pkg, bline_if, bline_front, bline_fifo and bline_back.
module bresenham_line_point_generator_unit
  import bline_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bline_req_if.sink  req_i,
  bline_cfg_if.sink  cfg_i,
  bline_pt_if.source pt_o
);

  localparam int unsigned ENTRY_W = entry_width(COORD_BITS);

  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0] push_data, pop_data;

  bline_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  bline_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  bline_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .cfg_i       (cfg_i),
    .pt_o        (pt_o)
  );

endmodule

### rtl/core/bline_checker.sv
// Port-level checker for the line point generator and its bind to the top level.
// Depends on bline_pkg for widths.
module bline_checker
  import bline_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  pt_valid_i,
  input logic                  pt_ready_i,
  input logic [COORD_BITS-1:0] point_x_i,
  input logic [COORD_BITS-1:0] point_y_i,
  input logic [PANEL_W-1:0]    panel_x_i,
  input logic [PANEL_W-1:0]    panel_y_i,
  input logic [COLOR_W-1:0]    point_color_i,
  input logic                  visible_i,
  input logic                  last_i
);

  // Reset drops any pending point
  assert property (@(posedge clk_i) !rst_ni |-> !pt_valid_i)
    else $error("point valid during reset");

  // Hold a stalled point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_valid_i && !pt_ready_i |=> pt_valid_i)
    else $error("point dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_valid_i && !pt_ready_i |=> $stable(point_x_i) && $stable(point_y_i)
      && $stable(panel_x_i) && $stable(panel_y_i) && $stable(point_color_i)
      && $stable(visible_i) && $stable(last_i))
    else $error("point payload changed while stalled");

  // Clip flag follows the coordinate signs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_valid_i |-> (visible_i == !(point_x_i[COORD_BITS-1] || point_y_i[COORD_BITS-1])))
    else $error("visible flag disagrees with coordinates");

endmodule

bind bresenham_line_point_generator_unit bline_checker #(
  .COORD_BITS (COORD_BITS)
) u_bline_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pt_valid_i    (pt_o.valid),
  .pt_ready_i    (pt_o.ready),
  .point_x_i     (pt_o.point_x),
  .point_y_i     (pt_o.point_y),
  .panel_x_i     (pt_o.panel_x),
  .panel_y_i     (pt_o.panel_y),
  .point_color_i (pt_o.point_color),
  .visible_i     (pt_o.visible),
  .last_i        (pt_o.last)
);
